// ===== hdl/pcob_pkg.sv =====
`default_nettype none

package pcob_pkg;

   // Table geometry
   localparam int NUM_COMMANDS = 64;
   localparam int IDX_W        = (NUM_COMMANDS > 1) ? $clog2(NUM_COMMANDS) : 1;

   // Field widths
   localparam int KIND_W    = 3;
   localparam int CMD_W     = 16;
   localparam int TIME_W    = 32;
   localparam int CNT_W     = 32;
   localparam int CFG_W     = 31;
   localparam int RATIO_W   = 7;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 3;

   // Failure ratio divider: quotient bits and the 100*failures numerator width
   localparam int DIV_STEPS = 7;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int NUM_W     = CNT_W + DIV_STEPS;

   // Request kinds (codes above KIND_READ behave as read)
   localparam logic [KIND_W-1:0] KIND_RECORD = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CHECK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FORCE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLOCK  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

   // Entry status codes
   localparam logic [STAT_W-1:0] ST_SERVING = 2'd0;
   localparam logic [STAT_W-1:0] ST_PAUSED  = 2'd1;
   localparam logic [STAT_W-1:0] ST_STOPPED = 2'd2;
   localparam logic [STAT_W-1:0] ST_KEEP    = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_CMD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_CMD    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REQ_LIMIT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_LIMIT = 3'd4;

   // Register reset values
   localparam logic [CMD_W-1:0]   FIRST_CMD_RST   = 16'd0;
   localparam logic [CMD_W-1:0]   LAST_CMD_RST    = 16'd63;
   localparam logic [CFG_W-1:0]   WINDOW_RST      = 31'd30;
   localparam logic [CFG_W-1:0]   REQ_LIMIT_RST   = 31'd60000;
   localparam logic [RATIO_W-1:0] RATIO_LIMIT_RST = 7'd80;

   localparam logic [CNT_W-1:0]   CNT_MAX        = '1;
   localparam logic [CNT_W-1:0]   FAIL_MIN_COUNT = 32'd10;
   localparam logic [RATIO_W-1:0] RATIO_MAX      = 7'd100;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [TIME_W-1:0]  wstart;
      logic [CNT_W-1:0]   req_total;
      logic [CNT_W-1:0]   req_win;
      logic [CNT_W-1:0]   fail_total;
      logic [CNT_W-1:0]   fail_win;
      logic [CNT_W-1:0]   req_peak;
      logic [RATIO_W-1:0] ratio_peak;
      logic [RATIO_W-1:0] ratio_win;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             accept;
      logic             clear_wr;
      logic [IDX_W-1:0] clear_idx;
      logic             load;
      logic             prep;
      logic             div_step;
      logic             finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_stat_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/per_command_overload_breaker.sv =====
`default_nettype none

// Per-command overload breaker. After reset the block sweeps its entry table
// to zero, holding busy high until the last entry is cleared; configuration
// writes are taken during that time. A request is taken when start is high
// and busy is low. Its result shows on the rsp_ ports, marked by rsp_valid
// high for one cycle. A request passes the states LOAD and FINISH and then
// the result register; a failed record also passes PREP, a setup step, and
// DIVIDE, the serial failure-ratio divider, one quotient bit a cycle, before
// FINISH. busy drops in the cycle the result shows, and no new request is
// taken before then. The one table port pair sets this: each request reads
// its entry, updates it and writes it back before the next may read. The
// receiver cannot stall results.
module per_command_overload_breaker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [pcob_pkg::KIND_W-1:0]        req_kind,
   input  logic [pcob_pkg::CMD_W-1:0]         req_cmd,
   input  logic [pcob_pkg::TIME_W-1:0]        req_now,
   input  logic [pcob_pkg::STAT_W-1:0]        req_new_status,
   input  logic signed [31:0]                 req_outcome,
   output logic                               rsp_valid,
   output logic                               rsp_in_range,
   output logic [pcob_pkg::STAT_W-1:0]        rsp_status_code,
   output logic [pcob_pkg::CNT_W-1:0]         rsp_total_requests,
   output logic [pcob_pkg::CNT_W-1:0]         rsp_peak_requests,
   output logic [pcob_pkg::CNT_W-1:0]         rsp_window_requests,
   output logic [pcob_pkg::CNT_W-1:0]         rsp_total_failures,
   output logic [pcob_pkg::RATIO_W-1:0]       rsp_peak_fail_ratio,
   output logic [pcob_pkg::RATIO_W-1:0]       rsp_window_fail_ratio,
   input  logic                               csr_we,
   input  logic [pcob_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcob_pkg::CFG_W-1:0]         csr_wdata
);

   pcob_pkg::ctrl_cmd_type cmd;
   pcob_pkg::dp_stat_type  stat;

   pcob_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   pcob_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_kind              (req_kind),
      .req_cmd               (req_cmd),
      .req_now               (req_now),
      .req_new_status        (req_new_status),
      .req_outcome           (req_outcome),
      .rsp_valid             (rsp_valid),
      .rsp_in_range          (rsp_in_range),
      .rsp_status_code       (rsp_status_code),
      .rsp_total_requests    (rsp_total_requests),
      .rsp_peak_requests     (rsp_peak_requests),
      .rsp_window_requests   (rsp_window_requests),
      .rsp_total_failures    (rsp_total_failures),
      .rsp_peak_fail_ratio   (rsp_peak_fail_ratio),
      .rsp_window_fail_ratio (rsp_window_fail_ratio)
   );

endmodule

`default_nettype wire

// ===== hdl/pcob_ram.sv =====
`default_nettype none

module pcob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/pcob_ctrl.sv =====
`default_nettype none

module pcob_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pcob_pkg::dp_stat_type stat,
   output pcob_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_PREP,
      S_DIVIDE,
      S_FINISH
   } state_type;

   localparam logic [pcob_pkg::IDX_W-1:0] LAST_IDX =
      pcob_pkg::IDX_W'(pcob_pkg::NUM_COMMANDS - 1);
   localparam logic [pcob_pkg::STEP_W-1:0] LAST_STEP =
      pcob_pkg::STEP_W'(pcob_pkg::DIV_STEPS - 1);

   state_type                     state_ff;
   logic [pcob_pkg::IDX_W-1:0]    clr_cnt_ff;
   logic [pcob_pkg::STEP_W-1:0]   step_ff;

   always_comb begin
      busy          = (state_ff != S_IDLE);
      cmd.accept    = start && (state_ff == S_IDLE);
      cmd.clear_wr  = (state_ff == S_CLEAR);
      cmd.clear_idx = clr_cnt_ff;
      cmd.load      = (state_ff == S_LOAD);
      cmd.prep      = (state_ff == S_PREP);
      cmd.div_step  = (state_ff == S_DIVIDE);
      cmd.finish    = (state_ff == S_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
         step_ff    <= '0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               // sweep the table to zero, one entry a cycle
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == LAST_IDX) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               state_ff <= stat.need_div ? S_PREP : S_FINISH;
            end
            S_PREP: begin
               step_ff  <= '0;
               state_ff <= S_DIVIDE;
            end
            S_DIVIDE: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_busy_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(cmd.accept))
      else $error("busy rose without an accepted request");

   a_finish_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !busy)
      else $error("block still busy after finishing a request");

   a_divide_len: assert property (@(posedge clock) disable iff (reset)
      cmd.prep |=> ##(pcob_pkg::DIV_STEPS) cmd.finish)
      else $error("divider did not run its full step count");

endmodule

`default_nettype wire

// ===== hdl/pcob_dp.sv =====
`default_nettype none

module pcob_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  pcob_pkg::ctrl_cmd_type             cmd,
   output pcob_pkg::dp_stat_type              stat,
   input  logic                               csr_we,
   input  logic [pcob_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcob_pkg::CFG_W-1:0]         csr_wdata,
   input  logic [pcob_pkg::KIND_W-1:0]        req_kind,
   input  logic [pcob_pkg::CMD_W-1:0]         req_cmd,
   input  logic [pcob_pkg::TIME_W-1:0]        req_now,
   input  logic [pcob_pkg::STAT_W-1:0]        req_new_status,
   input  logic signed [31:0]                 req_outcome,
   output logic                               rsp_valid,
   output logic                               rsp_in_range,
   output logic [pcob_pkg::STAT_W-1:0]        rsp_status_code,
   output logic [pcob_pkg::CNT_W-1:0]         rsp_total_requests,
   output logic [pcob_pkg::CNT_W-1:0]         rsp_peak_requests,
   output logic [pcob_pkg::CNT_W-1:0]         rsp_window_requests,
   output logic [pcob_pkg::CNT_W-1:0]         rsp_total_failures,
   output logic [pcob_pkg::RATIO_W-1:0]       rsp_peak_fail_ratio,
   output logic [pcob_pkg::RATIO_W-1:0]       rsp_window_fail_ratio
);

   // Configuration
   logic [pcob_pkg::CMD_W-1:0]   first_ff;
   logic [pcob_pkg::CMD_W-1:0]   last_ff;
   logic [pcob_pkg::CFG_W-1:0]   window_ff;
   logic [pcob_pkg::CFG_W-1:0]   limit_ff;
   logic [pcob_pkg::RATIO_W-1:0] ratio_lim_ff;
   logic [pcob_pkg::TIME_W-1:0]  clock_now_ff;

   // Latched request
   logic [pcob_pkg::KIND_W-1:0]  kind_ff;
   logic [pcob_pkg::STAT_W-1:0]  nstat_ff;
   logic                         failed_ff;
   logic                         ok_ff;
   logic [pcob_pkg::IDX_W-1:0]   idx_ff;

   // Working entry and divider
   pcob_pkg::entry_type          ent_ff;
   logic [pcob_pkg::NUM_W-1:0]   num_ff;
   logic [pcob_pkg::NUM_W-1:0]   dsh_ff;
   logic [pcob_pkg::RATIO_W-1:0] q_ff;

   // Result registers
   logic                         rsp_valid_ff;
   pcob_pkg::entry_type          rsp_ent_ff;
   logic                         rsp_ok_ff;

   logic [pcob_pkg::CMD_W:0]     diff;
   logic                         ok_in;
   logic [pcob_pkg::IDX_W-1:0]   idx_in;
   pcob_pkg::entry_type          cur;
   pcob_pkg::entry_type          upd;
   pcob_pkg::entry_type          fin_ent;
   logic [pcob_pkg::TIME_W-1:0]  elapsed;
   logic [pcob_pkg::RATIO_W-1:0] ratio;
   logic [pcob_pkg::NUM_W-1:0]   fw_ext;
   logic                         ram_we;
   logic [pcob_pkg::IDX_W-1:0]   ram_waddr;
   logic [pcob_pkg::ENTRY_W-1:0] ram_wdata;
   logic [pcob_pkg::ENTRY_W-1:0] ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= pcob_pkg::FIRST_CMD_RST;
         last_ff      <= pcob_pkg::LAST_CMD_RST;
         window_ff    <= pcob_pkg::WINDOW_RST;
         limit_ff     <= pcob_pkg::REQ_LIMIT_RST;
         ratio_lim_ff <= pcob_pkg::RATIO_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            pcob_pkg::CSR_FIRST_CMD:   first_ff     <= csr_wdata[pcob_pkg::CMD_W-1:0];
            pcob_pkg::CSR_LAST_CMD:    last_ff      <= csr_wdata[pcob_pkg::CMD_W-1:0];
            pcob_pkg::CSR_WINDOW:      window_ff    <= csr_wdata;
            pcob_pkg::CSR_REQ_LIMIT:   limit_ff     <= csr_wdata;
            pcob_pkg::CSR_RATIO_LIMIT: ratio_lim_ff <= csr_wdata[pcob_pkg::RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   // Map the command number onto a table entry
   always_comb begin
      diff   = {1'b0, req_cmd} - {1'b0, first_ff};
      ok_in  = (req_cmd >= first_ff) && (req_cmd <= last_ff) &&
               (diff < (pcob_pkg::CMD_W + 1)'(pcob_pkg::NUM_COMMANDS));
      idx_in = diff[pcob_pkg::IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_now_ff <= '0;
      end else if (cmd.accept &&
                   (req_kind == pcob_pkg::KIND_CHECK || req_kind == pcob_pkg::KIND_CLOCK)) begin
         clock_now_ff <= req_now;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff   <= req_kind;
         nstat_ff  <= req_new_status;
         failed_ff <= (req_outcome < 0);
         ok_ff     <= ok_in;
         idx_ff    <= idx_in;
      end
   end

   assign stat.need_div = ok_ff && (kind_ff == pcob_pkg::KIND_RECORD) && failed_ff;

   // Entry update; check sees clock_now already holding its own time
   always_comb begin
      cur     = pcob_pkg::entry_type'(ram_rdata);
      upd     = cur;
      elapsed = clock_now_ff - cur.wstart;
      case (kind_ff)
         pcob_pkg::KIND_RECORD: begin
            if (elapsed >= {1'b0, window_ff}) begin
               upd.wstart = clock_now_ff;
               if (cur.req_win > cur.req_peak) begin
                  upd.req_peak = cur.req_win;
               end
               if (cur.ratio_win > cur.ratio_peak) begin
                  upd.ratio_peak = cur.ratio_win;
               end
               upd.req_win   = '0;
               upd.fail_win  = '0;
               upd.ratio_win = '0;
            end else if (cur.req_win >= {1'b0, limit_ff}) begin
               upd.status = pcob_pkg::ST_PAUSED;
            end
            upd.req_total = pcob_pkg::sat_inc(cur.req_total);
            upd.req_win   = pcob_pkg::sat_inc(upd.req_win);
            if (failed_ff) begin
               upd.fail_total = pcob_pkg::sat_inc(cur.fail_total);
               upd.fail_win   = pcob_pkg::sat_inc(upd.fail_win);
            end
         end
         pcob_pkg::KIND_CHECK: begin
            if (cur.status == pcob_pkg::ST_PAUSED && elapsed > {1'b0, window_ff}) begin
               upd.status    = pcob_pkg::ST_SERVING;
               upd.wstart    = clock_now_ff;
               upd.req_win   = '0;
               upd.fail_win  = '0;
               upd.ratio_win = '0;
            end
         end
         pcob_pkg::KIND_FORCE: begin
            if (nstat_ff != pcob_pkg::ST_KEEP) begin
               upd.status = nstat_ff;
               if (nstat_ff == pcob_pkg::ST_SERVING) begin
                  upd.req_win   = '0;
                  upd.fail_win  = '0;
                  upd.ratio_win = '0;
               end
            end
         end
         default: ;
      endcase
   end

   assign fw_ext = {{(pcob_pkg::NUM_W - pcob_pkg::CNT_W){1'b0}}, ent_ff.fail_win};

   // 100*failures over requests, one quotient bit a step, restoring
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ent_ff <= upd;
      end
      if (cmd.prep) begin
         num_ff <= (fw_ext << 6) + (fw_ext << 5) + (fw_ext << 2);
         dsh_ff <= {1'b0, ent_ff.req_win, {(pcob_pkg::DIV_STEPS - 1){1'b0}}};
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         if (num_ff >= dsh_ff) begin
            num_ff <= num_ff - dsh_ff;
            q_ff   <= {q_ff[pcob_pkg::RATIO_W-2:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[pcob_pkg::RATIO_W-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
   end

   always_comb begin
      fin_ent = ent_ff;
      ratio   = (q_ff > pcob_pkg::RATIO_MAX) ? pcob_pkg::RATIO_MAX : q_ff;
      if (stat.need_div) begin
         fin_ent.ratio_win = ratio;
         if (ratio > ratio_lim_ff && ent_ff.fail_win > pcob_pkg::FAIL_MIN_COUNT) begin
            fin_ent.status = pcob_pkg::ST_PAUSED;
         end
      end
   end

   assign ram_we    = cmd.clear_wr || (cmd.finish && ok_ff);
   assign ram_waddr = cmd.clear_wr ? cmd.clear_idx : idx_ff;
   assign ram_wdata = cmd.clear_wr ? '0 : fin_ent;

   pcob_ram #(
      .WIDTH (pcob_pkg::ENTRY_W),
      .DEPTH (pcob_pkg::NUM_COMMANDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_in),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
      if (cmd.finish) begin
         rsp_ok_ff  <= ok_ff;
         rsp_ent_ff <= ok_ff ? fin_ent : '0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_in_range          = rsp_ok_ff;
   assign rsp_status_code       = rsp_ent_ff.status;
   assign rsp_total_requests    = rsp_ent_ff.req_total;
   assign rsp_peak_requests     = rsp_ent_ff.req_peak;
   assign rsp_window_requests   = rsp_ent_ff.req_win;
   assign rsp_total_failures    = rsp_ent_ff.fail_total;
   assign rsp_peak_fail_ratio   = rsp_ent_ff.ratio_peak;
   assign rsp_window_fail_ratio = rsp_ent_ff.ratio_win;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_ratio_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && stat.need_div) |-> (q_ff <= pcob_pkg::RATIO_MAX))
      else $error("failure ratio quotient above 100");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (cmd.clear_wr || $past(cmd.div_step) || $past(cmd.load)))
      else $error("table written outside a clear or a finishing request");

endmodule

`default_nettype wire
